>>> rtl/pbbs_pkg.sv
// ----------------------------------------------------------------------------
// pbbs_pkg
// Shared codes, constants and types for the power button and battery
// sequencer.
// ----------------------------------------------------------------------------
package pbbs_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_PINS    = 3'd1;
    localparam logic [2:0] OP_PRESS   = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_BATTERY = 3'd4;
    localparam logic [2:0] OP_APP     = 3'd5;

    localparam logic [1:0] PH_INIT       = 2'd0;
    localparam logic [1:0] PH_ACTIVATING = 2'd1;
    localparam logic [1:0] PH_ACTIVE     = 2'd2;
    localparam logic [1:0] PH_DEACT      = 2'd3;

    localparam logic [2:0] CFG_CHARGE_MASK = 3'd0;
    localparam logic [2:0] CFG_LOW_BOUND   = 3'd1;
    localparam logic [2:0] CFG_IDLE_CODE   = 3'd2;
    localparam logic [2:0] CFG_SHORT_HOLD  = 3'd3;
    localparam logic [2:0] CFG_LONG_HOLD   = 3'd4;
    localparam logic [2:0] CFG_TONE_WAIT   = 3'd5;

    localparam int unsigned ARM_SHORT = 0;
    localparam int unsigned ARM_LONG  = 1;
    localparam int unsigned ARM_TONE  = 2;

    localparam logic [15:0] VOLT_NONE  = 16'hFFFF;
    localparam logic [15:0] VOLT_MAX   = 16'hFFFE;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    // floor(y / 15) = (y * REC_MUL) >> REC_SHIFT for y < 2**19
    localparam logic [19:0] REC_MUL   = 20'd559241;
    localparam int unsigned REC_SHIFT = 23;

    typedef struct packed {
        logic [15:0] charge_mask;
        logic [15:0] low_bound_mv;
        logic [3:0]  idle_code;
        logic [15:0] short_hold_ticks;
        logic [15:0] long_hold_ticks;
        logic [15:0] tone_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic        regulator_on;
        logic        tone_start;
        logic        notify_on;
        logic        notify_off;
        logic        reboot_request;
        logic        halt;
        logic        start_polling;
        logic        refresh_indication;
        logic        charging;
        logic [15:0] voltage_mv;
    } result_t;

endpackage

>>> rtl/pbbs_cfg.sv
// ----------------------------------------------------------------------------
// pbbs_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module pbbs_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output pbbs_pkg::cfg_t      cfg
);
    import pbbs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CHARGE_MASK: cfg_next.charge_mask      = cfg_data;
                CFG_LOW_BOUND:   cfg_next.low_bound_mv     = cfg_data;
                CFG_IDLE_CODE:   cfg_next.idle_code        = cfg_data[3:0];
                CFG_SHORT_HOLD:  cfg_next.short_hold_ticks = cfg_data;
                CFG_LONG_HOLD:   cfg_next.long_hold_ticks  = cfg_data;
                CFG_TONE_WAIT:   cfg_next.tone_wait_ticks  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.charge_mask      <= 16'd1;
            cfg_reg.low_bound_mv     <= 16'd3400;
            cfg_reg.idle_code        <= 4'd0;
            cfg_reg.short_hold_ticks <= 16'd2000;
            cfg_reg.long_hold_ticks  <= 16'd10000;
            cfg_reg.tone_wait_ticks  <= 16'd900;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/pbbs_scale.sv
// ----------------------------------------------------------------------------
// pbbs_scale
// Battery reading scaling: raw * 37 / 15, saturated at 65534.
// ----------------------------------------------------------------------------
module pbbs_scale
(
    input  logic [15:0] raw,
    output logic [15:0] volt
);
    import pbbs_pkg::*;

    logic [18:0] raw_x7;
    logic [38:0] prod;
    logic [15:0] quot;
    logic [17:0] sum;

    // raw*37/15 = 2*raw + raw*7/15
    assign raw_x7 = {raw, 3'b000} - {3'b000, raw};
    assign prod   = {20'd0, raw_x7} * {19'd0, REC_MUL};
    assign quot   = prod[REC_SHIFT +: 16];
    assign sum    = {1'b0, raw, 1'b0} + {2'b00, quot};
    assign volt   = (sum > {2'b00, VOLT_MAX}) ? VOLT_MAX : sum[15:0];

endmodule

>>> rtl/pbbs_step.sv
// ----------------------------------------------------------------------------
// pbbs_step
// Sequencer state and the single-pass update for one item; state moves on
// when the item advances into the result register.
// ----------------------------------------------------------------------------
module pbbs_step
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [2:0]          op,
    input  logic [15:0]         pay,
    input  pbbs_pkg::cfg_t      cfg,
    output pbbs_pkg::result_t   result
);
    import pbbs_pkg::*;

    logic [1:0]  phase_reg,        phase_next;
    logic        charge_reg,       charge_next;
    logic        charge_known_reg, charge_known_next;
    logic [15:0] volt_reg,         volt_next;
    logic [15:0] short_count_reg,  short_count_next;
    logic [15:0] long_count_reg,   long_count_next;
    logic [15:0] tone_count_reg,   tone_count_next;
    logic [2:0]  armed_reg,        armed_next;
    logic        halted_reg,       halted_next;

    logic [15:0] scaled;
    logic        tone_start, notify_on, notify_off, reboot, poll, refresh;

    function automatic logic [15:0] bump(input logic [15:0] c);
        return (c != COUNT_MAX) ? c + 16'd1 : c;
    endfunction

    pbbs_scale u_scale
    (
        .raw  (pay),
        .volt (scaled)
    );

    always_comb
    begin
        phase_next        = phase_reg;
        charge_next       = charge_reg;
        charge_known_next = charge_known_reg;
        volt_next         = volt_reg;
        short_count_next  = short_count_reg;
        long_count_next   = long_count_reg;
        tone_count_next   = tone_count_reg;
        armed_next        = armed_reg;
        halted_next       = halted_reg;
        tone_start        = 1'b0;
        notify_on         = 1'b0;
        notify_off        = 1'b0;
        reboot            = 1'b0;
        poll              = 1'b0;
        refresh           = 1'b0;

        if (!halted_reg)
        begin
            unique case (op)
                OP_TICK:
                begin
                    if (armed_reg[ARM_SHORT])
                    begin
                        short_count_next = bump(short_count_reg);
                        if (short_count_next >= cfg.short_hold_ticks)
                        begin
                            armed_next[ARM_SHORT] = 1'b0;
                            if (phase_next == PH_INIT)
                            begin
                                phase_next           = PH_ACTIVATING;
                                tone_start           = 1'b1;
                                tone_count_next      = 16'd0;
                                armed_next[ARM_TONE] = 1'b1;
                            end
                            else if (phase_next == PH_ACTIVE)
                            begin
                                phase_next           = PH_DEACT;
                                tone_start           = 1'b1;
                                tone_count_next      = 16'd0;
                                armed_next[ARM_TONE] = 1'b1;
                                notify_off           = 1'b1;
                            end
                        end
                    end
                    if (armed_reg[ARM_LONG])
                    begin
                        long_count_next = bump(long_count_reg);
                        if (long_count_next >= cfg.long_hold_ticks)
                        begin
                            armed_next[ARM_LONG] = 1'b0;
                            if (phase_next == PH_ACTIVATING || phase_next == PH_ACTIVE)
                            begin
                                reboot = 1'b1;
                            end
                        end
                    end
                    // a tone restarted above still counts in this tick if it was already armed
                    if (armed_reg[ARM_TONE] && armed_next[ARM_TONE])
                    begin
                        tone_count_next = bump(tone_count_next);
                        if (tone_count_next >= cfg.tone_wait_ticks)
                        begin
                            armed_next[ARM_TONE] = 1'b0;
                            if (phase_next == PH_ACTIVATING)
                            begin
                                phase_next = PH_ACTIVE;
                                notify_on  = 1'b1;
                                refresh    = 1'b1;
                            end
                            else if (phase_next == PH_DEACT)
                            begin
                                halted_next = 1'b1;
                            end
                        end
                    end
                end
                OP_PINS:
                begin
                    if (phase_reg != PH_DEACT)
                    begin
                        charge_next       = |(pay & cfg.charge_mask);
                        charge_known_next = 1'b1;
                    end
                    if (phase_reg == PH_INIT)
                    begin
                        refresh = 1'b1;
                    end
                    else if (phase_reg == PH_ACTIVE)
                    begin
                        if (!charge_next && volt_reg < cfg.low_bound_mv)
                        begin
                            phase_next           = PH_DEACT;
                            tone_start           = 1'b1;
                            tone_count_next      = 16'd0;
                            armed_next[ARM_TONE] = 1'b1;
                            notify_off           = 1'b1;
                        end
                        else
                        begin
                            refresh = 1'b1;
                        end
                    end
                end
                OP_PRESS:
                begin
                    short_count_next      = 16'd0;
                    armed_next[ARM_SHORT] = 1'b1;
                    if (phase_reg == PH_INIT)
                    begin
                        long_count_next      = 16'd0;
                        armed_next[ARM_LONG] = 1'b1;
                    end
                end
                OP_RELEASE:
                begin
                    armed_next[ARM_SHORT] = 1'b0;
                    if (phase_reg != PH_DEACT)
                    begin
                        armed_next[ARM_LONG] = 1'b0;
                    end
                end
                OP_BATTERY:
                begin
                    if (phase_reg != PH_DEACT)
                    begin
                        volt_next = scaled;
                    end
                    if (phase_reg == PH_INIT)
                    begin
                        poll    = (volt_reg == VOLT_NONE);
                        refresh = 1'b1;
                    end
                    else if (phase_reg == PH_ACTIVE)
                    begin
                        if (charge_known_reg && !charge_reg && volt_next < cfg.low_bound_mv)
                        begin
                            phase_next           = PH_DEACT;
                            tone_start           = 1'b1;
                            tone_count_next      = 16'd0;
                            armed_next[ARM_TONE] = 1'b1;
                            notify_off           = 1'b1;
                        end
                        else
                        begin
                            refresh = 1'b1;
                        end
                    end
                end
                OP_APP:
                begin
                    if (phase_reg == PH_ACTIVE && pay == {12'd0, cfg.idle_code})
                    begin
                        phase_next           = PH_DEACT;
                        tone_start           = 1'b1;
                        tone_count_next      = 16'd0;
                        armed_next[ARM_TONE] = 1'b1;
                        notify_off           = 1'b1;
                    end
                end
                default:
                begin
                    halted_next = halted_reg;
                end
            endcase
        end

        result.phase              = phase_next;
        result.regulator_on       = (phase_next != PH_INIT);
        result.tone_start         = tone_start;
        result.notify_on          = notify_on;
        result.notify_off         = notify_off;
        result.reboot_request     = reboot;
        result.halt               = halted_next;
        result.start_polling      = poll;
        result.refresh_indication = refresh;
        result.charging           = charge_next;
        result.voltage_mv         = volt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_INIT;
            charge_reg       <= 1'b0;
            charge_known_reg <= 1'b0;
            volt_reg         <= VOLT_NONE;
            short_count_reg  <= 16'd0;
            long_count_reg   <= 16'd0;
            tone_count_reg   <= 16'd0;
            armed_reg        <= 3'd0;
            halted_reg       <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            charge_reg       <= charge_next;
            charge_known_reg <= charge_known_next;
            volt_reg         <= volt_next;
            short_count_reg  <= short_count_next;
            long_count_reg   <= long_count_next;
            tone_count_reg   <= tone_count_next;
            armed_reg        <= armed_next;
            halted_reg       <= halted_next;
        end
    end

endmodule

>>> rtl/power_button_battery_sequencer.sv
// Timing: the item sits in the input register and moves into the result
// register once the output is free of a result held by result_stall.
// Throughput: one item per cycle unless stalled; single-pass update is the limit.
// Reset: asynchronous, active low; phase initialising, voltage 65535, timers
// disarmed, configuration back to its defaults.
// ----------------------------------------------------------------------------
// power_button_battery_sequencer
// Four-phase power sequencer driven by millisecond ticks and button,
// pin, battery and application events.
// ----------------------------------------------------------------------------
module power_button_battery_sequencer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  operation,
    input  logic [15:0] payload,

    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  phase,
    output logic        regulator_on,
    output logic        tone_start,
    output logic        notify_on,
    output logic        notify_off,
    output logic        reboot_request,
    output logic        halt,
    output logic        start_polling,
    output logic        refresh_indication,
    output logic        charging,
    output logic [15:0] voltage_mv,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pbbs_pkg::*;

    cfg_t        cfg;
    result_t     step_result;

    logic        item_vld_reg, item_vld_next;
    logic [2:0]  op_reg;
    logic [15:0] pay_reg;
    logic        res_vld_reg, res_vld_next;
    result_t     res_reg;

    logic        item_take;
    logic        out_free;
    logic        advance;

    pbbs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbbs_step u_step
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .op      (op_reg),
        .pay     (pay_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    assign out_free      = !res_vld_reg || !result_stall;
    assign advance       = item_vld_reg && out_free;
    assign item_stall    = item_vld_reg && !out_free;
    assign item_take     = item_valid && !item_stall;
    assign item_vld_next = item_take || (item_vld_reg && !advance);
    assign res_vld_next  = advance || (res_vld_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            op_reg  <= operation;
            pay_reg <= payload;
        end
        if (advance)
        begin
            res_reg <= step_result;
        end
    end

    assign result_valid       = res_vld_reg;
    assign phase              = res_reg.phase;
    assign regulator_on       = res_reg.regulator_on;
    assign tone_start         = res_reg.tone_start;
    assign notify_on          = res_reg.notify_on;
    assign notify_off         = res_reg.notify_off;
    assign reboot_request     = res_reg.reboot_request;
    assign halt               = res_reg.halt;
    assign start_polling      = res_reg.start_polling;
    assign refresh_indication = res_reg.refresh_indication;
    assign charging           = res_reg.charging;
    assign voltage_mv         = res_reg.voltage_mv;

endmodule
